>>> hdl/ohs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_pkg: shared types and codes for the open-addressing hash set
// Field widths, operation codes, result codes and slot states used by the
// request/response interfaces and the hash set core.
// ----------------------------------------------------------------------------
package ohs_pkg;

    // Field widths of the request and response channels and of the slot state
    localparam int KIND_W   = 2;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 8;
    localparam int SLOT_W   = 2;

    // Bits of the key folded per cycle by the home-slot reduction
    localparam int DIGIT_W  = 4;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [KEY_IN_W-1:0] key_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [TOTAL_W-1:0]  total_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    // Operation codes
    localparam kind_t OP_INSERT = 2'd0;
    localparam kind_t OP_REMOVE = 2'd1;
    localparam kind_t OP_LOOKUP = 2'd2;
    localparam kind_t OP_CLEAR  = 2'd3;

    // Result codes
    localparam status_t RES_NONE = 2'd0;
    localparam status_t RES_DONE = 2'd1;
    localparam status_t RES_FULL = 2'd2;

    // Slot states
    localparam slot_t SLOT_EMPTY = 2'd0;
    localparam slot_t SLOT_USED  = 2'd1;
    localparam slot_t SLOT_TOMB  = 2'd2;

endpackage

>>> hdl/ohs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_req_if: request channel of the hash set
// Valid/ready channel carrying one operation code and one key per request.
// ----------------------------------------------------------------------------
interface ohs_req_if
    import ohs_pkg::*;
();
    logic  valid;
    logic  ready;
    kind_t kind;
    key_t  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

>>> hdl/ohs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_rsp_if: response channel of the hash set
// Valid/ready channel carrying the status and occupied-slot total.
// ----------------------------------------------------------------------------
interface ohs_rsp_if
    import ohs_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    total_t  entry_total;

    modport source (output valid, output status, output entry_total, input ready);
    modport sink   (input valid, input status, input entry_total, output ready);
endinterface

>>> hdl/open_addressing_hash_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_set_top: hash set with linear probing
// Use: send requests (insert, remove, lookup, clear) on req; each request
// gives exactly one response on rsp with a status and the occupied total.
// Slot states and keys live in one synchronous RAM (one read, one write
// port, registered read), probed one slot per cycle while not held by a stall.
// Home slot: the low key bits when TABLE_SIZE is a power of two, else
// the key mod TABLE_SIZE, folded 4 key bits per cycle; then the slots
// are probed in turn, and the response is registered at the last probe.
// A new request is accepted only after the previous one has finished;
// an insert into a tombstone keeps probing forward for a duplicate.
// Clear sweeps the RAM, one slot per cycle, holding at the last slot
// while the output register is busy. Reset: a clearing pass over every
// slot runs after reset, with no response; req.ready stays low until it ends.
// Stall: a finished response waits in the output register; the next request
// is still accepted and processed, and holds at its last probe until the
// output register is free.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_top
    import ohs_pkg::*;
#(
    parameter int TABLE_SIZE = 128,
    parameter int KEY_BITS   = 32
)(
    input  logic      clk,
    input  logic      rst_n,
    ohs_req_if.sink   req,
    ohs_rsp_if.source rsp
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int PRB_W   = IDX_W + 1;
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W   = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int KX_W    = (KEY_W > IDX_W) ? KEY_W : IDX_W;
    localparam int NDIG    = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W   = NDIG * DIGIT_W;
    localparam int DIG_CW  = $clog2(NDIG + 1);
    localparam int TOT_X_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int WORD_W  = SLOT_W + KEY_W;
    localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [PRB_W-1:0]  LAST_PROBE = PRB_W'(TABLE_SIZE - 1);
    localparam logic [PRB_W-1:0]  REM_N      = PRB_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(TABLE_SIZE);
    localparam logic [DIG_CW-1:0] DIG_LAST   = DIG_CW'(NDIG);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_SEEK  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;

    // Control registers
    logic [2:0]        state_reg,    state_next;
    logic [IDX_W-1:0]  slot_reg,     slot_next;
    logic [PRB_W-1:0]  probe_reg,    probe_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [DIG_CW-1:0] dig_cnt_reg,  dig_cnt_next;
    logic              clr_emit_reg, clr_emit_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    kind_t             kind_reg,     kind_next;
    logic [KEY_W-1:0]  key_reg,      key_next;
    logic [IDX_W-1:0]  rem_reg,      rem_next;
    logic [PAD_W-1:0]  dig_sh_reg,   dig_sh_next;
    status_t           out_status_reg, out_status_next;
    total_t            out_total_reg,  out_total_next;

    // Slot RAM: {slot state, key}
    logic [WORD_W-1:0] mem [TABLE_SIZE];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic              wr_en;

    logic [KEY_W-1:0]   key_in;
    logic [KX_W-1:0]    key_x;
    logic [IDX_W-1:0]   home_pow2;
    logic [IDX_W-1:0]   rem_step;
    slot_t              rd_status;
    logic [KEY_W-1:0]   rd_key;
    logic               key_hit;
    logic               can_emit;
    logic [IDX_W-1:0]   slot_inc;
    logic               last_probe;
    logic               fin;
    logic               emit;
    status_t            res_status;
    logic [TOT_X_W-1:0] cnt_x;

    // Input key cut to the key width; pow2 home is the low bits
    assign key_in    = KEY_W'(req.key);
    assign key_x     = KX_W'(key_reg);
    assign home_pow2 = key_x[IDX_W-1:0];

    // Read word decode and probe helpers
    assign rd_status  = rd_data_reg[WORD_W-1 -: SLOT_W];
    assign rd_key     = rd_data_reg[KEY_W-1:0];
    assign key_hit    = (rd_status == SLOT_USED) && (rd_key == key_reg);
    assign can_emit   = !out_valid_reg || rsp.ready;
    assign slot_inc   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign last_probe = (probe_reg == LAST_PROBE);
    assign emit       = fin && can_emit;

    // Home slot reduction: fold DIGIT_W key bits into key mod TABLE_SIZE
    always_comb
    begin : rem_fold
        logic [PRB_W-1:0] rw;
        logic [IDX_W-1:0] acc;
        acc = rem_reg;
        for (int b = 0; b < DIGIT_W; b++)
        begin
            rw = {acc, dig_sh_reg[PAD_W-1-b]};
            if (rw >= REM_N)
            begin
                rw = rw - REM_N;
            end
            acc = rw[IDX_W-1:0];
        end
        rem_step = acc;
    end

    // Sequencer: hash, probe, seek a duplicate, write back, sweep
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        probe_next    = probe_reg;
        count_next    = count_reg;
        dig_cnt_next  = dig_cnt_reg;
        clr_emit_next = clr_emit_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        rem_next      = rem_reg;
        dig_sh_next   = dig_sh_reg;
        rd_addr       = slot_inc;
        wr_en         = 1'b0;
        wr_addr       = slot_reg;
        wr_word       = {SLOT_USED, key_reg};
        fin           = 1'b0;
        res_status    = RES_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next     = req.kind;
                    key_next      = key_in;
                    rem_next      = '0;
                    dig_sh_next   = PAD_W'(key_in);
                    dig_cnt_next  = '0;
                    slot_next     = '0;
                    clr_emit_next = 1'b1;
                    state_next    = (req.kind == OP_CLEAR) ? S_SWEEP : S_HASH;
                end
            end

            S_HASH:
            begin
                if (IS_POW2)
                begin
                    rd_addr    = home_pow2;
                    slot_next  = home_pow2;
                    probe_next = '0;
                    state_next = S_PROBE;
                end
                else if (dig_cnt_reg == DIG_LAST)
                begin
                    rd_addr    = rem_reg;
                    slot_next  = rem_reg;
                    probe_next = '0;
                    state_next = S_PROBE;
                end
                else
                begin
                    rem_next     = rem_step;
                    dig_sh_next  = dig_sh_reg << DIGIT_W;
                    dig_cnt_next = dig_cnt_reg + 1'b1;
                end
            end

            S_PROBE:
            begin
                slot_next  = slot_inc;
                probe_next = probe_reg + 1'b1;
                if (kind_reg == OP_INSERT)
                begin
                    if (key_hit)
                    begin
                        // already present
                        fin = 1'b1;
                    end
                    else if (rd_status != SLOT_USED)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (rd_status == SLOT_EMPTY || last_probe)
                        begin
                            fin        = 1'b1;
                            res_status = RES_DONE;
                        end
                        else
                        begin
                            // filled a tombstone: drop a later duplicate
                            state_next = S_SEEK;
                        end
                    end
                    else if (last_probe)
                    begin
                        fin        = 1'b1;
                        res_status = RES_FULL;
                    end
                end
                else
                begin
                    if (rd_status == SLOT_EMPTY)
                    begin
                        fin = 1'b1;
                    end
                    else if (key_hit)
                    begin
                        fin        = 1'b1;
                        res_status = RES_DONE;
                        if (kind_reg == OP_REMOVE)
                        begin
                            wr_en      = 1'b1;
                            wr_word    = {SLOT_TOMB, key_reg};
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (last_probe)
                    begin
                        fin = 1'b1;
                    end
                end
            end

            S_SEEK:
            begin
                slot_next  = slot_inc;
                probe_next = probe_reg + 1'b1;
                if (key_hit)
                begin
                    wr_en      = 1'b1;
                    wr_word    = {SLOT_TOMB, key_reg};
                    count_next = count_reg - 1'b1;
                    fin        = 1'b1;
                end
                else if (rd_status == SLOT_EMPTY || last_probe)
                begin
                    fin        = 1'b1;
                    res_status = RES_DONE;
                end
            end

            S_SWEEP:
            begin
                wr_en     = 1'b1;
                wr_word   = {SLOT_EMPTY, key_reg};
                slot_next = slot_inc;
                if (slot_reg == LAST_SLOT)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                    fin        = clr_emit_reg;
                    res_status = RES_DONE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register busy: hold this probe and re-read its slot;
        // otherwise a finished request goes back to idle
        if (fin && !can_emit)
        begin
            wr_en      = 1'b0;
            count_next = count_reg;
            state_next = state_reg;
            slot_next  = slot_reg;
            probe_next = probe_reg;
            rd_addr    = slot_reg;
        end
        else if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    // Response register
    assign cnt_x = TOT_X_W'(count_next);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_total_next  = cnt_x[TOTAL_W-1:0];
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            slot_reg      <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            dig_cnt_reg   <= '0;
            clr_emit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            dig_cnt_reg   <= dig_cnt_next;
            clr_emit_reg  <= clr_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        rem_reg        <= rem_next;
        dig_sh_reg     <= dig_sh_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

    // Slot RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_total = out_total_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("occupied count above table size");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_status == RES_FULL) |-> (count_reg == CNT_MAX))
        else $error("full status with free slots");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && kind_reg == OP_CLEAR) |=> (rsp.entry_total == '0))
        else $error("clear left a nonzero total");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_SEEK) |-> (probe_reg <= LAST_PROBE))
        else $error("probe ran past the table");
`endif

endmodule
